// ----- hdl/bds_pkg.sv -----
// Shared types, divisor tables and helpers for the baud divider search block.
// No dependencies; used by every module of the block.
`default_nettype none
package bds_pkg;

    localparam int RATE_W   = 30;
    localparam int DSR_W    = 18;  // 7 * 32768 fits in 18 bits
    localparam int PRE_CNT  = 4;
    localparam int SCL_CNT  = 16;
    localparam int PRE_W    = $clog2(PRE_CNT);
    localparam int SCL_W    = $clog2(SCL_CNT);
    localparam int STEP_W   = $clog2(RATE_W);
    localparam logic [RATE_W-1:0] CLK_HZ_RESET = 30'd80000000;

    localparam logic [2:0] PRESCALER_DIV [PRE_CNT] = '{3'd2, 3'd3, 3'd5, 3'd7};
    localparam logic [15:0] SCALER_DIV [SCL_CNT] = '{
        16'd2, 16'd4, 16'd6, 16'd8, 16'd16, 16'd32, 16'd64, 16'd128,
        16'd256, 16'd512, 16'd1024, 16'd2048, 16'd4096, 16'd8192,
        16'd16384, 16'd32768
    };

    // combined divisor of one prescaler / scaler setting
    function automatic logic [DSR_W-1:0] div_product(
        input logic [PRE_W-1:0] p,
        input logic [SCL_W-1:0] s
    );
        logic [DSR_W:0] prod;
        prod = {{(DSR_W-2){1'b0}}, PRESCALER_DIV[p]} * {3'b000, SCALER_DIV[s]};
        return prod[DSR_W-1:0];
    endfunction

    typedef struct packed {
        logic init;      // latch request, clear best, restart at prescaler 0
        logic load_mid;  // take bisection midpoint and start a probe
        logic load_nb;   // take neighbor index and start a probe
        logic eval_mid;  // apply a bisection probe result
        logic eval_nb;   // apply a neighbor probe result
        logic next_pre;  // move to next prescaler, reset bounds
        logic load_out;  // move best setting to the output register
    } bds_cmd_t;

    typedef struct packed {
        logic div_done;
        logic exact;     // best rate equals the request
        logic span_gt1;  // high - low > 1
        logic last_pre;
        logic out_free;
    } bds_status_t;

endpackage
`default_nettype wire

// ----- hdl/bds_div.sv -----
// Restoring serial divider: one quotient bit per cycle.
// Depends on bds_pkg for widths.
`default_nettype none
module bds_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bds_pkg::RATE_W-1:0]    dividend,
    input  wire logic [bds_pkg::DSR_W-1:0]     divisor,
    output logic                               done,
    output logic [bds_pkg::RATE_W-1:0]         quotient
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [bds_pkg::STEP_W-1:0]     cnt_reg, cnt_next;
    logic [bds_pkg::RATE_W-1:0]     quo_reg, quo_next;
    logic [bds_pkg::DSR_W-1:0]      rem_reg, rem_next;
    logic [bds_pkg::DSR_W-1:0]      dsr_reg, dsr_next;

    logic [bds_pkg::DSR_W:0]        trial;
    logic [bds_pkg::DSR_W:0]        diff;
    logic                           ge;

    assign trial = {rem_reg, quo_reg[bds_pkg::RATE_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = bds_pkg::STEP_W'(bds_pkg::RATE_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[bds_pkg::RATE_W-2:0], ge};
            rem_next = ge ? diff[bds_pkg::DSR_W-1:0] : trial[bds_pkg::DSR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- hdl/bds_dp.sv -----
// Datapath: clock register, search bounds, best-so-far, probe divider, output register.
// Depends on bds_pkg and bds_div.
`default_nettype none
module bds_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bds_pkg::bds_cmd_t             cmd,
    output bds_pkg::bds_status_t               status,
    input  wire logic                          cfg_we,
    input  wire logic [bds_pkg::RATE_W-1:0]    cfg_data,
    input  wire logic [bds_pkg::RATE_W-1:0]    req_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bds_pkg::PRE_W-1:0]          out_pre,
    output logic [bds_pkg::SCL_W-1:0]          out_scl,
    output logic [bds_pkg::RATE_W-1:0]         out_rate
);

    logic [bds_pkg::RATE_W-1:0] clk_hz_reg, clk_hz_next;
    logic [bds_pkg::RATE_W-1:0] req_reg, req_next;
    logic [bds_pkg::RATE_W-1:0] best_reg, best_next;
    logic [bds_pkg::PRE_W-1:0]  best_p_reg, best_p_next;
    logic [bds_pkg::SCL_W-1:0]  best_s_reg, best_s_next;
    logic [bds_pkg::PRE_W-1:0]  p_reg, p_next;
    logic [bds_pkg::SCL_W-1:0]  low_reg, low_next;
    logic [bds_pkg::SCL_W-1:0]  high_reg, high_next;
    logic [bds_pkg::SCL_W-1:0]  mid_reg, mid_next;
    logic [bds_pkg::SCL_W-1:0]  probe_reg, probe_next;
    logic                       out_valid_reg, out_valid_next;
    logic [bds_pkg::PRE_W-1:0]  out_pre_reg, out_pre_next;
    logic [bds_pkg::SCL_W-1:0]  out_scl_reg, out_scl_next;
    logic [bds_pkg::RATE_W-1:0] out_rate_reg, out_rate_next;

    logic [bds_pkg::SCL_W:0]    bound_sum;
    logic [bds_pkg::SCL_W-1:0]  mid_pick;
    logic [bds_pkg::SCL_W-1:0]  nb_pick;
    logic [bds_pkg::SCL_W-1:0]  probe_sel;
    logic [bds_pkg::SCL_W-1:0]  span;
    logic                       div_start;
    logic                       div_done;
    logic [bds_pkg::RATE_W-1:0] rate;

    assign bound_sum = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid_pick  = bound_sum[bds_pkg::SCL_W:1];
    assign nb_pick   = (high_reg == mid_reg) ? low_reg : high_reg;
    assign probe_sel = cmd.load_mid ? mid_pick : nb_pick;
    assign div_start = cmd.load_mid | cmd.load_nb;
    assign span      = high_reg - low_reg;

    bds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clk_hz_reg),
        .divisor  (bds_pkg::div_product(p_reg, probe_sel)),
        .done     (div_done),
        .quotient (rate)
    );

    always_comb
    begin
        clk_hz_next    = cfg_we ? cfg_data : clk_hz_reg;
        req_next       = req_reg;
        best_next      = best_reg;
        best_p_next    = best_p_reg;
        best_s_next    = best_s_reg;
        p_next         = p_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        probe_next     = probe_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_pre_next   = out_pre_reg;
        out_scl_next   = out_scl_reg;
        out_rate_next  = out_rate_reg;

        if (cmd.init)
        begin
            req_next    = req_in;
            best_next   = '0;
            best_p_next = '0;
            best_s_next = '0;
            p_next      = '0;
            low_next    = '0;
            high_next   = bds_pkg::SCL_W'(bds_pkg::SCL_CNT - 1);
        end
        if (cmd.load_mid)
        begin
            mid_next   = mid_pick;
            probe_next = mid_pick;
        end
        if (cmd.load_nb)
            probe_next = nb_pick;
        if (cmd.eval_mid)
        begin
            if (rate > req_reg)
                low_next = mid_reg;
            else
            begin
                high_next = mid_reg;
                if (rate > best_reg)
                begin
                    best_next   = rate;
                    best_p_next = p_reg;
                    best_s_next = probe_reg;
                end
            end
        end
        if (cmd.eval_nb && rate <= req_reg && rate > best_reg)
        begin
            best_next   = rate;
            best_p_next = p_reg;
            best_s_next = probe_reg;
        end
        if (cmd.next_pre)
        begin
            p_next    = p_reg + 1'b1;
            low_next  = '0;
            high_next = bds_pkg::SCL_W'(bds_pkg::SCL_CNT - 1);
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_pre_next   = best_p_reg;
            out_scl_next   = best_s_reg;
            out_rate_next  = best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg    <= bds_pkg::CLK_HZ_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clk_hz_reg    <= clk_hz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        best_reg     <= best_next;
        best_p_reg   <= best_p_next;
        best_s_reg   <= best_s_next;
        p_reg        <= p_next;
        low_reg      <= low_next;
        high_reg     <= high_next;
        mid_reg      <= mid_next;
        probe_reg    <= probe_next;
        out_pre_reg  <= out_pre_next;
        out_scl_reg  <= out_scl_next;
        out_rate_reg <= out_rate_next;
    end

    always_comb
    begin
        status.div_done = div_done;
        status.exact    = (best_reg == req_reg);
        status.span_gt1 = (span > bds_pkg::SCL_W'(1));
        status.last_pre = (p_reg == bds_pkg::PRE_W'(bds_pkg::PRE_CNT - 1));
        status.out_free = ~out_valid_reg | out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_pre   = out_pre_reg;
    assign out_scl   = out_scl_reg;
    assign out_rate  = out_rate_reg;

endmodule
`default_nettype wire

// ----- hdl/bds_ctrl.sv -----
// Search sequencer: bisection per prescaler, neighbor probe, early exit on exact match.
// Depends on bds_pkg for command and status structs.
`default_nettype none
module bds_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire bds_pkg::bds_status_t  status,
    output bds_pkg::bds_cmd_t          cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MID      = 3'd1;
    localparam logic [2:0] ST_WAIT_MID = 3'd2;
    localparam logic [2:0] ST_CHK      = 3'd3;
    localparam logic [2:0] ST_NB       = 3'd4;
    localparam logic [2:0] ST_WAIT_NB  = 3'd5;
    localparam logic [2:0] ST_END_PRE  = 3'd6;
    localparam logic [2:0] ST_FINISH   = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.init   = 1'b1;
                    state_next = ST_MID;
                end
            end
            ST_MID:
            begin
                cmd.load_mid = 1'b1;
                state_next   = ST_WAIT_MID;
            end
            ST_WAIT_MID:
            begin
                if (status.div_done)
                begin
                    cmd.eval_mid = 1'b1;
                    state_next   = ST_CHK;
                end
            end
            ST_CHK:
            begin
                // exact match ends this bisection; a neighbor could not beat it
                if (status.exact)
                    state_next = ST_END_PRE;
                else if (status.span_gt1)
                    state_next = ST_MID;
                else
                    state_next = ST_NB;
            end
            ST_NB:
            begin
                cmd.load_nb = 1'b1;
                state_next  = ST_WAIT_NB;
            end
            ST_WAIT_NB:
            begin
                if (status.div_done)
                begin
                    cmd.eval_nb = 1'b1;
                    state_next  = ST_END_PRE;
                end
            end
            ST_END_PRE:
            begin
                if (status.exact || status.last_pre)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.next_pre = 1'b1;
                    state_next   = ST_MID;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ----- hdl/baud_divider_search_top.sv -----
// Top level of the baud divider search: sequencer plus datapath.
// Depends on bds_pkg, bds_ctrl, bds_dp (and bds_div below it).
//
//   channel   | handshake              | payload
//   ----------+------------------------+-------------------------------------------
//   request   | in_valid / in_ready    | requested_rate_hz[29:0]
//   result    | out_valid / out_ready  | prescaler_index, scaler_index,
//             |                        | achieved_rate_hz
//   config    | cfg_we (no wait)       | input_clock_hz[29:0]
//
// Each probe is one pass of the shared restoring divider: a load step, the serial quotient
// steps, a done step that applies the probe result and a decision step.
// A request runs 4 to 5 probes per prescaler (fewer on an exact hit), at most 20
// probes in all, and a last step then posts the result to the result register.
// One request is in work at a time; in_ready is high only while the sequencer is idle.
// The result register frees the search: a new request is taken while a result still
// waits on out_ready, and a finished search holds only if that register is still full.
// Reset clears the sequencer and result valid and loads input_clock_hz to 80 MHz.
`default_nettype none
module baud_divider_search_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bds_pkg::RATE_W-1:0]    input_clock_hz,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bds_pkg::RATE_W-1:0]    requested_rate_hz,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bds_pkg::PRE_W-1:0]          prescaler_index,
    output logic [bds_pkg::SCL_W-1:0]          scaler_index,
    output logic [bds_pkg::RATE_W-1:0]         achieved_rate_hz
);

    bds_pkg::bds_cmd_t    cmd;
    bds_pkg::bds_status_t status;

    // sequencer: walks prescalers, bisection steps and neighbor probe
    bds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: bounds, best setting, serial divider, result register
    bds_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_data  (input_clock_hz),
        .req_in    (requested_rate_hz),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pre   (prescaler_index),
        .out_scl   (scaler_index),
        .out_rate  (achieved_rate_hz)
    );

endmodule
`default_nettype wire

// ----- hdl/bds_check.sv -----
// Port-level checker for baud_divider_search_top, with its bind statement.
// Depends on bds_pkg for widths.
`default_nettype none
module bds_check (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [bds_pkg::PRE_W-1:0]     prescaler_index,
    input  wire logic [bds_pkg::SCL_W-1:0]     scaler_index,
    input  wire logic [bds_pkg::RATE_W-1:0]    achieved_rate_hz
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(achieved_rate_hz)
            && $stable(prescaler_index) && $stable(scaler_index))
        else $error("result changed while stalled");

    // no fit means indices are zero too
    a_zero_fit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && achieved_rate_hz == '0 |-> prescaler_index == '0 && scaler_index == '0)
        else $error("zero rate with nonzero indices");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while search busy");

    // a result cannot appear the cycle after a request
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result before any probe");

endmodule

bind baud_divider_search_top bds_check u_bds_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .prescaler_index  (prescaler_index),
    .scaler_index     (scaler_index),
    .achieved_rate_hz (achieved_rate_hz)
);
`default_nettype wire
